/* hw/rtl/fds_pkg.sv */
// Shared types, constants and register codes of the directory entry scanner.
`default_nettype none

package fds_pkg;

  // Sector geometry and the kept-entry ordinal limit
  localparam int SECTOR_LENGTH = 512;
  localparam int ENTRY_BYTES   = 32;
  localparam logic [4:0] COUNT_LIMIT =
    5'((SECTOR_LENGTH / ENTRY_BYTES > 31) ? 31 : SECTOR_LENGTH / ENTRY_BYTES);

  // Configuration port
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_RESERVED        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COPIES          = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TABLE_SIZE      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROOT_ENTRIES    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SECTOR_BYTES    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CLUSTER_SECTORS = 3'd5;

  // Register reset values and the data-region start they give
  localparam logic [15:0] RESERVED_RESET        = 16'd1;
  localparam logic [7:0]  COPIES_RESET          = 8'd2;
  localparam logic [15:0] TABLE_SIZE_RESET      = 16'd9;
  localparam logic [15:0] ROOT_ENTRIES_RESET    = 16'd224;
  localparam logic [12:0] SECTOR_BYTES_RESET    = 13'd512;
  localparam logic [7:0]  CLUSTER_SECTORS_RESET = 8'd1;
  localparam logic [31:0] DATA_START_RESET      = 32'(1 + 2 * 9 + (224 * 32) / 512);

  // Entry byte markers
  localparam logic [7:0] DOT_MARK     = 8'h2E;
  localparam logic [7:0] DELETED_MARK = 8'hE5;
  localparam logic [7:0] END_MARK     = 8'h00;
  localparam logic [7:0] LFN_ATTR     = 8'h0F;
  localparam int         DIR_BIT      = 4;

  // Byte offsets inside one entry
  localparam logic [4:0] OFF_NAME0   = 5'd0;
  localparam logic [4:0] OFF_ATTR    = 5'd11;
  localparam logic [4:0] OFF_TIME_LO = 5'd22;
  localparam logic [4:0] OFF_TIME_HI = 5'd23;
  localparam logic [4:0] OFF_DATE_LO = 5'd24;
  localparam logic [4:0] OFF_DATE_HI = 5'd25;
  localparam logic [4:0] OFF_CLUS_LO = 5'd26;
  localparam logic [4:0] OFF_CLUS_HI = 5'd27;
  localparam logic [4:0] OFF_SIZE_0  = 5'd28;
  localparam logic [4:0] OFF_SIZE_1  = 5'd29;
  localparam logic [4:0] OFF_SIZE_2  = 5'd30;
  localparam logic [4:0] OFF_LAST    = 5'd31;

  localparam logic [11:0] YEAR_BASE = 12'd1980;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  // Raw fields of one kept entry
  typedef struct packed {
    logic [4:0]  entry_number;
    logic [7:0]  attributes;
    logic [15:0] cluster;
    logic [31:0] size;
    logic [15:0] mod_time;
    logic [15:0] mod_date;
  } rec_t;

  // Unpacked result word
  typedef struct packed {
    logic [4:0]  entry_number;
    logic [7:0]  attributes;
    logic        is_directory;
    logic [15:0] first_cluster;
    logic [31:0] first_sector;
    logic [31:0] file_size;
    logic [11:0] modified_year;
    logic [3:0]  modified_month;
    logic [4:0]  modified_day;
    logic [4:0]  modified_hour;
    logic [5:0]  modified_minute;
    logic [5:0]  modified_second;
  } res_t;

endpackage

`default_nettype wire

/* hw/rtl/fds_cfg.sv */
// Boot-parameter registers and the multi-cycle data-region start calculation.
`default_nettype none

module fds_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [fds_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [fds_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                               busy,
  output logic [7:0]                         cluster_sectors,
  output logic [31:0]                        data_start
);
  import fds_pkg::*;

  localparam int NUM_W  = 21;
  localparam int STEP_W = 5;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOAD = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_SUM  = 2'd3;

  logic [15:0] rsc_r, rsc_nxt;
  logic [7:0]  copies_r, copies_nxt;
  logic [15:0] tsize_r, tsize_nxt;
  logic [15:0] root_r, root_nxt;
  logic [12:0] sbytes_r, sbytes_nxt;
  logic [7:0]  csec_r, csec_nxt;
  logic        hit;

  logic [1:0]        state_r, state_nxt;
  logic [NUM_W-1:0]  num_r, num_nxt;
  logic [12:0]       rem_r, rem_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [31:0]       ds_r, ds_nxt;

  logic [13:0] rem_sh;
  logic        ge;
  logic [23:0] table_prod;
  logic [NUM_W-1:0] quot;

  always_comb begin
    rsc_nxt    = rsc_r;
    copies_nxt = copies_r;
    tsize_nxt  = tsize_r;
    root_nxt   = root_r;
    sbytes_nxt = sbytes_r;
    csec_nxt   = csec_r;
    hit        = 1'b0;
    if (cfg_we) begin
      hit = 1'b1;
      case (cfg_index)
        REG_RESERVED:        rsc_nxt    = cfg_data;
        REG_COPIES:          copies_nxt = cfg_data[7:0];
        REG_TABLE_SIZE:      tsize_nxt  = cfg_data;
        REG_ROOT_ENTRIES:    root_nxt   = cfg_data;
        REG_SECTOR_BYTES:    sbytes_nxt = cfg_data[12:0];
        REG_CLUSTER_SECTORS: csec_nxt   = cfg_data[7:0];
        default:             hit        = 1'b0;
      endcase
    end
  end

  // One restoring-division step per cycle: root_entries*32 / sector_bytes
  assign rem_sh     = {rem_r, num_r[NUM_W-1]};
  assign ge         = rem_sh >= {1'b0, sbytes_r};
  assign table_prod = copies_r * tsize_r;
  assign quot       = (sbytes_r == 13'd0) ? '0 : num_r;

  always_comb begin
    state_nxt = state_r;
    num_nxt   = num_r;
    rem_nxt   = rem_r;
    step_nxt  = step_r;
    ds_nxt    = ds_r;
    case (state_r)
      ST_IDLE: ;
      ST_LOAD: begin
        num_nxt   = {root_r, 5'b0};
        rem_nxt   = '0;
        step_nxt  = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        rem_nxt  = ge ? 13'(rem_sh - {1'b0, sbytes_r}) : rem_sh[12:0];
        num_nxt  = {num_r[NUM_W-2:0], ge};
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(NUM_W - 1)) begin
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        ds_nxt    = 32'(rsc_r) + 32'(table_prod) + 32'(quot);
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
    // A new write restarts the calculation from the fresh registers
    if (hit) begin
      state_nxt = ST_LOAD;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rsc_r    <= RESERVED_RESET;
      copies_r <= COPIES_RESET;
      tsize_r  <= TABLE_SIZE_RESET;
      root_r   <= ROOT_ENTRIES_RESET;
      sbytes_r <= SECTOR_BYTES_RESET;
      csec_r   <= CLUSTER_SECTORS_RESET;
      state_r  <= ST_IDLE;
      ds_r     <= DATA_START_RESET;
    end else begin
      rsc_r    <= rsc_nxt;
      copies_r <= copies_nxt;
      tsize_r  <= tsize_nxt;
      root_r   <= root_nxt;
      sbytes_r <= sbytes_nxt;
      csec_r   <= csec_nxt;
      state_r  <= state_nxt;
      ds_r     <= ds_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r  <= num_nxt;
    rem_r  <= rem_nxt;
    step_r <= step_nxt;
  end

  assign busy            = state_r != ST_IDLE;
  assign cluster_sectors = csec_r;
  assign data_start      = ds_r;

endmodule

`default_nettype wire

/* hw/rtl/fds_front.sv */
// Byte capture and entry classification; pushes one record per kept entry.
`default_nettype none

module fds_front (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        accept,
  input  wire logic [7:0]  data_byte,
  input  wire logic        sector_end,
  output logic             rec_push,
  output fds_pkg::rec_t    rec
);
  import fds_pkg::*;

  logic [4:0]  off_r, off_nxt;
  logic [4:0]  kept_r, kept_nxt;
  logic        stop_r, stop_nxt;
  logic        skip_r, skip_nxt;
  logic [4:0]  kept_inc;

  logic [7:0]  attr_r;
  logic [15:0] time_r;
  logic [15:0] date_r;
  logic [15:0] clus_r;
  logic [23:0] size_r;

  assign kept_inc = (kept_r < COUNT_LIMIT) ? kept_r + 5'd1 : kept_r;
  assign rec_push = accept && (off_r == OFF_LAST) && !stop_r && !skip_r;

  always_comb begin
    off_nxt  = off_r;
    kept_nxt = kept_r;
    stop_nxt = stop_r;
    skip_nxt = skip_r;
    if (accept) begin
      if (off_r == OFF_NAME0) begin
        skip_nxt = (data_byte == DOT_MARK) || (data_byte == DELETED_MARK);
        if (data_byte == END_MARK) begin
          stop_nxt = 1'b1;
        end
      end
      if ((off_r == OFF_ATTR) && (data_byte == LFN_ATTR)) begin
        skip_nxt = 1'b1;
      end
      if (rec_push) begin
        kept_nxt = kept_inc;
      end
      off_nxt = off_r + 5'd1;
      if (sector_end) begin
        off_nxt  = '0;
        kept_nxt = '0;
        stop_nxt = 1'b0;
        skip_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r  <= '0;
      kept_r <= '0;
      stop_r <= 1'b0;
      skip_r <= 1'b0;
    end else begin
      off_r  <= off_nxt;
      kept_r <= kept_nxt;
      stop_r <= stop_nxt;
      skip_r <= skip_nxt;
    end
  end

  // Every held field is rewritten inside each entry before its last byte
  always_ff @(posedge clk) begin
    if (accept) begin
      case (off_r)
        OFF_ATTR:    attr_r        <= data_byte;
        OFF_TIME_LO: time_r[7:0]   <= data_byte;
        OFF_TIME_HI: time_r[15:8]  <= data_byte;
        OFF_DATE_LO: date_r[7:0]   <= data_byte;
        OFF_DATE_HI: date_r[15:8]  <= data_byte;
        OFF_CLUS_LO: clus_r[7:0]   <= data_byte;
        OFF_CLUS_HI: clus_r[15:8]  <= data_byte;
        OFF_SIZE_0:  size_r[7:0]   <= data_byte;
        OFF_SIZE_1:  size_r[15:8]  <= data_byte;
        OFF_SIZE_2:  size_r[23:16] <= data_byte;
        default: ;
      endcase
    end
  end

  always_comb begin
    rec.entry_number = kept_inc;
    rec.attributes   = attr_r;
    rec.cluster      = clus_r;
    rec.size         = {data_byte, size_r};
    rec.mod_time     = time_r;
    rec.mod_date     = date_r;
  end

endmodule

`default_nettype wire

/* hw/rtl/fds_queue.sv */
// Short record queue between the front and the back.
`default_nettype none

module fds_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire fds_pkg::rec_t rec_in,
  input  wire logic          pop,
  output fds_pkg::rec_t      rec_out,
  output logic               full,
  output logic               empty
);
  import fds_pkg::*;

  rec_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_r, rd_r;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full    = cnt_r == QCNT_W'(QUEUE_DEPTH);
  assign empty   = cnt_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rec_out = slot_r[rd_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (do_pop) begin
        rd_r <= rd_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_r] <= rec_in;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("record pushed into a full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty))
    else $error("record popped from an empty queue");

  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (wr_r - rd_r) == QPTR_W'($past(cnt_r) + 1'b1))
    else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

/* hw/rtl/fds_back.sv */
// Result stage: first-sector multiply, date and time unpacking, output register.
`default_nettype none

module fds_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_empty,
  input  wire fds_pkg::rec_t q_rec,
  output logic               q_pop,
  input  wire logic [7:0]    cluster_sectors,
  input  wire logic [31:0]   data_start,
  output logic               res_valid,
  input  wire logic          res_pop,
  output fds_pkg::res_t      res
);
  import fds_pkg::*;

  logic               a_v_r, a_v_nxt;
  rec_t               a_rec_r;
  logic signed [25:0] a_prod_r, a_prod_nxt;
  logic signed [16:0] cdiff;

  logic o_v_r, o_v_nxt;
  res_t o_res_r, o_res_nxt;

  logic o_load, a_take;

  assign o_load = a_v_r && (!o_v_r || res_pop);
  assign a_take = !a_v_r || o_load;
  assign q_pop  = !q_empty && a_take;

  // Cluster minus two may go negative; the signed product wraps like 32-bit math
  assign cdiff      = $signed(17'({1'b0, q_rec.cluster}) - 17'd2);
  assign a_prod_nxt = cdiff * $signed({1'b0, cluster_sectors});

  assign a_v_nxt = a_take ? q_pop : a_v_r;
  assign o_v_nxt = o_load ? 1'b1 : (res_pop ? 1'b0 : o_v_r);

  always_comb begin
    o_res_nxt.entry_number    = a_rec_r.entry_number;
    o_res_nxt.attributes      = a_rec_r.attributes;
    o_res_nxt.is_directory    = a_rec_r.attributes[DIR_BIT];
    o_res_nxt.first_cluster   = a_rec_r.cluster;
    o_res_nxt.first_sector    = {{6{a_prod_r[25]}}, a_prod_r} + data_start;
    o_res_nxt.file_size       = a_rec_r.size;
    o_res_nxt.modified_year   = 12'(a_rec_r.mod_date[15:9]) + YEAR_BASE;
    o_res_nxt.modified_month  = a_rec_r.mod_date[8:5];
    o_res_nxt.modified_day    = a_rec_r.mod_date[4:0];
    o_res_nxt.modified_hour   = a_rec_r.mod_time[15:11];
    o_res_nxt.modified_minute = a_rec_r.mod_time[10:5];
    o_res_nxt.modified_second = {a_rec_r.mod_time[4:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else begin
      a_v_r <= a_v_nxt;
      o_v_r <= o_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      a_rec_r  <= q_rec;
      a_prod_r <= a_prod_nxt;
    end
    if (o_load) begin
      o_res_r <= o_res_nxt;
    end
  end

  assign res_valid = o_v_r;
  assign res       = o_res_r;

endmodule

`default_nettype wire

/* hw/rtl/fat_directory_entry_scanner.sv */
// Top level of the directory entry scanner: front, record queue, back and config unit.
`default_nettype none

// Throughput: one byte per cycle; outside register writes, in_full rises only when
// the record queue is full.
// A kept entry's word reaches the out_ ports through the record queue, the product
// register and the result register, when the result register is free.
// A register write recomputes the data-region start in a load step, one divide
// bit per cycle and a sum step; in_full stays high until the new value is registered.
// Reset (rst_n low, synchronous) restores the boot defaults, data start 33,
// and empties the queue and the result register.
module fat_directory_entry_scanner (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // input queue side
  input  wire logic                           in_push,
  output logic                                in_full,
  input  wire logic [7:0]                     in_data_byte,
  input  wire logic                           in_sector_end,
  // result queue side
  output logic                                out_empty,
  input  wire logic                           out_pop,
  output logic [4:0]                          out_entry_number,
  output logic [7:0]                          out_attributes,
  output logic                                out_is_directory,
  output logic [15:0]                         out_first_cluster,
  output logic [31:0]                         out_first_sector,
  output logic [31:0]                         out_file_size,
  output logic [11:0]                         out_modified_year,
  output logic [3:0]                          out_modified_month,
  output logic [4:0]                          out_modified_day,
  output logic [4:0]                          out_modified_hour,
  output logic [5:0]                          out_modified_minute,
  output logic [5:0]                          out_modified_second,
  // configuration write port
  input  wire logic                           cfg_we,
  input  wire logic [fds_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [fds_pkg::CFG_DATA_W-1:0] cfg_data
);
  import fds_pkg::*;

  logic        accept;
  logic        rec_push;
  rec_t        rec_front;
  rec_t        rec_q;
  logic        q_full, q_empty, q_pop;
  logic        cfg_busy;
  logic [7:0]  cluster_sectors;
  logic [31:0] data_start;
  logic        res_valid;
  res_t        res;

  // Hold off bytes while the queue is full, a register is written or the data start is being rebuilt
  assign in_full = q_full || cfg_busy || cfg_we;
  assign accept  = in_push && !in_full;

  fds_cfg u_cfg (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .busy            (cfg_busy),
    .cluster_sectors (cluster_sectors),
    .data_start      (data_start)
  );

  // Front: track byte offset, classify the entry, latch fields
  fds_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .data_byte  (in_data_byte),
    .sector_end (in_sector_end),
    .rec_push   (rec_push),
    .rec        (rec_front)
  );

  // Decouple the byte stream from result back-pressure
  fds_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (rec_push),
    .rec_in  (rec_front),
    .pop     (q_pop),
    .rec_out (rec_q),
    .full    (q_full),
    .empty   (q_empty)
  );

  // Back: multiply for first sector, add data start, unpack, register
  fds_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_rec           (rec_q),
    .q_pop           (q_pop),
    .cluster_sectors (cluster_sectors),
    .data_start      (data_start),
    .res_valid       (res_valid),
    .res_pop         (out_pop),
    .res             (res)
  );

  assign out_empty           = !res_valid;
  assign out_entry_number    = res.entry_number;
  assign out_attributes      = res.attributes;
  assign out_is_directory    = res.is_directory;
  assign out_first_cluster   = res.first_cluster;
  assign out_first_sector    = res.first_sector;
  assign out_file_size       = res.file_size;
  assign out_modified_year   = res.modified_year;
  assign out_modified_month  = res.modified_month;
  assign out_modified_day    = res.modified_day;
  assign out_modified_hour   = res.modified_hour;
  assign out_modified_minute = res.modified_minute;
  assign out_modified_second = res.modified_second;

endmodule

`default_nettype wire
